// ===== hw/rtl/tti_pkg.sv =====
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, constants and the default breakpoint curve of the thermistor
// table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

	typedef struct packed {
		logic signed [15:0] adc;
		logic signed [15:0] temp;
	} entry_t;

	typedef enum logic {
		OP_CONVERT = 1'b0,
		OP_WRITE   = 1'b1
	} op_e;

	localparam int TBL_IDX_W = 6;
	localparam int NUM_W     = 34;
	localparam int DEN_W     = 17;
	localparam int QUO_W     = 33;
	localparam int DIV_STEPS = 32;

	localparam logic signed [15:0] HOT_LIMIT = 16'sd255;
	localparam logic signed [15:0] TEMP_MIN  = -16'sd32768;

	function automatic entry_t default_entry(input logic [TBL_IDX_W-1:0] idx);
		entry_t e;
		case (idx)
			6'd0:    e = '{adc: 16'sd1,    temp: 16'sd841};
			6'd1:    e = '{adc: 16'sd54,   temp: 16'sd255};
			6'd2:    e = '{adc: 16'sd107,  temp: 16'sd209};
			6'd3:    e = '{adc: 16'sd160,  temp: 16'sd184};
			6'd4:    e = '{adc: 16'sd213,  temp: 16'sd166};
			6'd5:    e = '{adc: 16'sd266,  temp: 16'sd153};
			6'd6:    e = '{adc: 16'sd319,  temp: 16'sd142};
			6'd7:    e = '{adc: 16'sd372,  temp: 16'sd132};
			6'd8:    e = '{adc: 16'sd425,  temp: 16'sd124};
			6'd9:    e = '{adc: 16'sd478,  temp: 16'sd116};
			6'd10:   e = '{adc: 16'sd531,  temp: 16'sd108};
			6'd11:   e = '{adc: 16'sd584,  temp: 16'sd101};
			6'd12:   e = '{adc: 16'sd637,  temp: 16'sd93};
			6'd13:   e = '{adc: 16'sd690,  temp: 16'sd86};
			6'd14:   e = '{adc: 16'sd743,  temp: 16'sd78};
			6'd15:   e = '{adc: 16'sd796,  temp: 16'sd70};
			6'd16:   e = '{adc: 16'sd849,  temp: 16'sd61};
			6'd17:   e = '{adc: 16'sd902,  temp: 16'sd50};
			6'd18:   e = '{adc: 16'sd955,  temp: 16'sd34};
			6'd19:   e = '{adc: 16'sd1008, temp: 16'sd3};
			default: e = '{adc: 16'sd0,    temp: 16'sd0};
		endcase
		return e;
	endfunction

endpackage

// ===== hw/rtl/tti_table.sv =====
// ----------------------------------------------------------------------------
// tti_table
// Breakpoint memory with one write port and one registered read port. Entries
// that were never written read as the default curve.
// ----------------------------------------------------------------------------
module tti_table #(
	parameter int NUM_ENTRIES = 20,
	localparam int IDX_W = $clog2(NUM_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  tti_pkg::entry_t   wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output tti_pkg::entry_t   rd_data
);
	import tti_pkg::*;

	entry_t               mem [NUM_ENTRIES];
	entry_t               rd_mem_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 rd_written_q;
	logic [NUM_ENTRIES-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
			rd_idx_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_mem_q : default_entry(TBL_IDX_W'(rd_idx_q));

endmodule

// ===== hw/rtl/tti_div.sv =====
// ----------------------------------------------------------------------------
// tti_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module tti_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tti_pkg::NUM_W-1:0]   num,
	input  logic signed [tti_pkg::DEN_W-1:0]   den,
	output logic                               done,
	output logic signed [tti_pkg::QUO_W-1:0]   quo
);
	import tti_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam int MAG_W = QUO_W - 1;
	localparam int DV_W  = DEN_W - 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [MAG_W-1:0]      dq_q;
	logic [DV_W-1:0]       dv_q;
	logic [DV_W-1:0]       rem_q;
	logic                  neg_q;
	logic [NUM_W-1:0]      num_neg;
	logic [DEN_W-1:0]      den_neg;
	logic [DEN_W-1:0]      shifted;
	logic                  fits;

	assign num_neg = -num;
	assign den_neg = -den;
	assign shifted = {rem_q, dq_q[MAG_W-1]};
	assign fits    = shifted >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
			dv_q  <= den[DEN_W-1] ? den_neg[DV_W-1:0] : den[DV_W-1:0];
			rem_q <= '0;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? DV_W'(shifted - {1'b0, dv_q}) : shifted[DV_W-1:0];
			dq_q  <= {dq_q[MAG_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

endmodule

// ===== hw/rtl/thermistor_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Converts a thermistor ADC reading to Celsius by a walk over a breakpoint
// memory, linear interpolation and an iterative divide.
//
//   Channel  Direction  Handshake             Payload
//   request  in         in_valid / in_ready   op, reading, entry_index,
//                                             entry_adc, entry_temp
//   result   out        out_valid / out_ready celsius
//
// A write request completes in the cycle it is accepted and gives no result.
// A conversion does one memory read per cycle during the walk, then at most a
// multiply and 32 divider steps.
// After reset the table reads as the default curve at once; no clearing pass.
// A finished result waits until the output register is free; a new request
// is taken while the previous result is still held there.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator #(
	parameter int NUM_ENTRIES = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [9:0]         reading,
	input  logic [4:0]         entry_index,
	input  logic signed [15:0] entry_adc,
	input  logic signed [15:0] entry_temp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] celsius
);
	import tti_pkg::*;

	localparam int IDX_W  = $clog2(NUM_ENTRIES);
	localparam int WIDX_W = (IDX_W > 5) ? IDX_W : 5;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_MUL   = 6'b000100,
		S_START = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [9:0]                reading_q;
	logic [IDX_W-1:0]          issue_q;
	logic                      issuing_q;
	logic                      chk_vld_s1;
	logic [IDX_W-1:0]          chk_idx_s1;
	entry_t                    prev_q;
	entry_t                    cur_q;
	logic signed [NUM_W-1:0]   prod_q;
	logic signed [DEN_W-1:0]   den_q;
	logic signed [15:0]        res_q;
	logic                      out_valid_q;
	logic signed [15:0]        celsius_q;

	logic                      accept;
	logic                      wr_en;
	logic                      wr_ok;
	logic [WIDX_W-1:0]         widx;
	entry_t                    wr_data;
	logic                      rd_en;
	entry_t                    rd_data;
	logic                      hit;
	logic                      last;
	logic signed [DEN_W-1:0]   dx;
	logic signed [DEN_W-1:0]   dt;
	logic signed [DEN_W-1:0]   width;
	logic                      div_done;
	logic signed [QUO_W-1:0]   quo;
	logic signed [NUM_W-1:0]   val;
	logic                      load;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign widx     = WIDX_W'(entry_index);
	assign wr_ok    = {27'd0, entry_index} < 32'(NUM_ENTRIES);
	assign wr_en    = accept && (op == OP_WRITE) && wr_ok;
	assign wr_data  = '{adc: entry_adc, temp: entry_temp};
	assign rd_en    = (state_q == S_SCAN) && issuing_q;

	tti_table #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (widx[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (issue_q),
		.rd_data (rd_data)
	);

	assign hit   = rd_data.adc > $signed({6'd0, reading_q});
	assign last  = chk_idx_s1 == IDX_W'(NUM_ENTRIES - 1);
	assign dx    = $signed({7'd0, reading_q}) - $signed({prev_q.adc[15], prev_q.adc});
	assign dt    = $signed({cur_q.temp[15], cur_q.temp}) - $signed({prev_q.temp[15], prev_q.temp});
	assign width = $signed({cur_q.adc[15], cur_q.adc}) - $signed({prev_q.adc[15], prev_q.adc});

	tti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_START),
		.num    (prod_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign val  = $signed({{(NUM_W - 16){prev_q.temp[15]}}, prev_q.temp})
		+ $signed({quo[QUO_W-1], quo});
	assign load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_q     <= '0;
			issuing_q   <= 1'b0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= rd_en;
			if (rd_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_CONVERT)) begin
						state_q   <= S_SCAN;
						issue_q   <= '0;
						issuing_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (chk_vld_s1 && (chk_idx_s1 != '0) && hit) begin
						state_q   <= S_MUL;
						issuing_q <= 1'b0;
					end else if (chk_vld_s1 && (chk_idx_s1 != '0) && last) begin
						state_q   <= S_DONE;
						issuing_q <= 1'b0;
					end else if (rd_en && (issue_q == IDX_W'(NUM_ENTRIES - 1))) begin
						issuing_q <= 1'b0;
					end
				end
				S_MUL: begin
					state_q <= (width == '0) ? S_DONE : S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= issue_q;
		if (accept) begin
			reading_q <= reading;
		end
		if ((state_q == S_SCAN) && chk_vld_s1) begin
			if ((chk_idx_s1 != '0) && hit) begin
				cur_q <= rd_data;
			end else begin
				prev_q <= rd_data;
				res_q  <= HOT_LIMIT;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= dx * dt;
			den_q  <= width;
			res_q  <= HOT_LIMIT;
		end
		if ((state_q == S_DIV) && div_done) begin
			if (val > $signed(NUM_W'(HOT_LIMIT))) begin
				res_q <= HOT_LIMIT;
			end else if (val < $signed({{(NUM_W - 16){1'b1}}, TEMP_MIN})) begin
				res_q <= TEMP_MIN;
			end else begin
				res_q <= val[15:0];
			end
		end
		if (load) begin
			celsius_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign celsius   = celsius_q;

endmodule

// ===== hw/rtl/tti_checker.sv =====
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks of the thermistor table interpolator, bound to the top
// level.
// ----------------------------------------------------------------------------
module tti_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               op,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] celsius
);
	import tti_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(celsius))
		else $error("Result changed or dropped while stalled.");

	a_out_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (celsius <= HOT_LIMIT))
		else $error("Result above the hot limit.");

	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_CONVERT) |=> !in_ready)
		else $error("Request taken while a conversion is in progress.");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_WRITE) |=> in_ready)
		else $error("Table write did not complete in one cycle.");

endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.celsius   (celsius)
);
